// ===== rtl/crsb_pkg.sv =====
// Shared types and constants for the clipped run-coded sprite blitter.
`default_nettype none

package crsb_pkg;

  localparam int DEFAULT_MAX_SCREEN_DIM = 4096;

  localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd320;
  localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd240;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_POS_X,
    REG_POS_Y,
    REG_SCREEN_WIDTH,
    REG_SCREEN_HEIGHT
  } cfg_reg_t;

  // Pixel placement request from the stream parser, before clipping.
  typedef struct packed {
    logic        is_pixel;
    logic [16:0] column;
    logic [15:0] line;
    logic [31:0] color;
    logic        done;
  } pix_req_t;

  // One result item as delivered on the output channel.
  typedef struct packed {
    logic        write_enable;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] color;
    logic        frame_done;
  } result_t;

  // Occupancy of the output buffer.
  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/crsb_parse.sv =====
// Stream parser: header, run and pixel sequencing with line and column tracking.
`default_nettype none

module crsb_parse
  import crsb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [31:0] word,
  output pix_req_t         req
);

  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_DIM  = 3'd2;
  localparam logic [2:0] PH_RUNS = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_LEN  = 3'd5;
  localparam logic [2:0] PH_PIX  = 3'd6;

  localparam logic [16:0] COLUMN_MAX = 17'h1FFFF;

  logic [2:0]  phase, phase_next;
  logic [15:0] sprite_height, sprite_height_next;
  logic [15:0] line_index, line_index_next;
  logic [15:0] runs_left, runs_left_next;
  logic [15:0] pixels_left, pixels_left_next;
  logic [16:0] column, column_next;
  logic        done;

  logic [15:0] low;
  logic [15:0] line_inc;
  logic [15:0] runs_dec;
  logic [15:0] pixels_dec;
  logic [17:0] skip_sum;
  logic        line_last;

  assign low        = word[15:0];
  assign line_inc   = line_index + 16'd1;
  assign runs_dec   = runs_left - 16'd1;
  assign pixels_dec = pixels_left - 16'd1;
  assign skip_sum   = {1'b0, column} + {2'b00, low};
  assign line_last  = (line_inc >= sprite_height);

  always_comb begin
    phase_next         = phase;
    sprite_height_next = sprite_height;
    line_index_next    = line_index;
    runs_left_next     = runs_left;
    pixels_left_next   = pixels_left;
    column_next        = column;
    done               = 1'b0;
    case (phase)
      PH_SIG: begin
        phase_next = PH_SIZE;
      end
      PH_SIZE: begin
        phase_next = PH_DIM;
      end
      PH_DIM: begin
        sprite_height_next = low;
        line_index_next    = '0;
        column_next        = '0;
        runs_left_next     = '0;
        pixels_left_next   = '0;
        if (low == 16'd0) begin
          phase_next = PH_SIG;
          done       = 1'b1;
        end else begin
          phase_next = PH_RUNS;
        end
      end
      PH_RUNS: begin
        runs_left_next = low;
        column_next    = '0;
        if (low == 16'd0) begin
          // empty line
          if (line_last) begin
            phase_next      = PH_SIG;
            line_index_next = '0;
            done            = 1'b1;
          end else begin
            phase_next      = PH_RUNS;
            line_index_next = line_inc;
          end
        end else begin
          phase_next = PH_SKIP;
        end
      end
      PH_SKIP: begin
        column_next = skip_sum[17] ? COLUMN_MAX : skip_sum[16:0];
        phase_next  = PH_LEN;
      end
      PH_LEN, PH_PIX: begin
        if (phase == PH_PIX) begin
          if (column != COLUMN_MAX) begin
            column_next = column + 17'd1;
          end
          pixels_left_next = pixels_dec;
        end else begin
          pixels_left_next = low;
        end
        if (phase == PH_LEN && low != 16'd0) begin
          phase_next = PH_PIX;
        end else if (phase == PH_PIX && pixels_dec != 16'd0) begin
          phase_next = PH_PIX;
        end else begin
          // run finished
          runs_left_next = runs_dec;
          if (runs_dec != 16'd0) begin
            phase_next = PH_SKIP;
          end else if (line_last) begin
            phase_next      = PH_SIG;
            line_index_next = '0;
            column_next     = '0;
            done            = 1'b1;
          end else begin
            phase_next      = PH_RUNS;
            line_index_next = line_inc;
            column_next     = '0;
          end
        end
      end
      default: begin
        phase_next = PH_SIG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIG;
      sprite_height <= '0;
      line_index    <= '0;
      runs_left     <= '0;
      pixels_left   <= '0;
      column        <= '0;
    end else if (step) begin
      phase         <= phase_next;
      sprite_height <= sprite_height_next;
      line_index    <= line_index_next;
      runs_left     <= runs_left_next;
      pixels_left   <= pixels_left_next;
      column        <= column_next;
    end
  end

  // placement uses the column and line before this word's update
  assign req.is_pixel = (phase == PH_PIX);
  assign req.column   = column;
  assign req.line     = line_index;
  assign req.color    = word;
  assign req.done     = done;

endmodule

`default_nettype wire

// ===== rtl/crsb_clip.sv =====
// Screen placement and per-pixel clipping of one parsed word.
`default_nettype none

module crsb_clip
  import crsb_pkg::*;
#(
  parameter int MAX_SCREEN_DIM = DEFAULT_MAX_SCREEN_DIM
) (
  input  wire logic [15:0] pos_x,
  input  wire logic [15:0] pos_y,
  input  wire logic [12:0] screen_width,
  input  wire logic [12:0] screen_height,
  input  wire pix_req_t    req,
  output result_t          res
);

  localparam logic [18:0] MaxDim = 19'(MAX_SCREEN_DIM);

  logic signed [18:0] x;
  logic signed [18:0] y;
  logic [18:0]        lim_x;
  logic [18:0]        lim_y;
  logic               visible;

  assign x = signed'({{3{pos_x[15]}}, pos_x}) + signed'({2'b00, req.column});
  assign y = signed'({{3{pos_y[15]}}, pos_y}) + signed'({3'b000, req.line});

  assign lim_x = ({6'd0, screen_width} < MaxDim) ? {6'd0, screen_width} : MaxDim;
  assign lim_y = ({6'd0, screen_height} < MaxDim) ? {6'd0, screen_height} : MaxDim;

  // nonnegative, so the sign bit is clear and an unsigned compare is exact
  assign visible = req.is_pixel && !x[18] && !y[18] &&
                   (unsigned'(x) < lim_x) && (unsigned'(y) < lim_y);

  assign res.write_enable = visible;
  assign res.pixel_x      = visible ? x[11:0] : 12'd0;
  assign res.pixel_y      = visible ? y[11:0] : 12'd0;
  assign res.color        = visible ? req.color : 32'd0;
  assign res.frame_done   = req.done;

endmodule

`default_nettype wire

// ===== rtl/crsb_outbuf.sv =====
// Result register with skid entry; its fill state sets the input stall.
`default_nettype none

module crsb_outbuf
  import crsb_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t din,
  output result_t      dout,
  output logic         dout_valid,
  input  wire logic    dout_stall,
  output buf_stat_t    stat
);

  result_t main_data;
  result_t skid_data;
  logic    main_valid;
  logic    skid_valid;
  logic    pop;

  assign pop = main_valid && !dout_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else if (!push) begin
        main_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else if (push) begin
        main_data <= din;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= din;
      end else begin
        main_data <= din;
      end
    end
  end

  assign dout            = main_data;
  assign dout_valid      = main_valid;
  assign stat.main_valid = main_valid;
  assign stat.skid_valid = skid_valid;

endmodule

`default_nettype wire

// ===== rtl/clipped_run_sprite_blitter.sv =====
// Top level of the clipped run-coded sprite blitter.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid / in_stall        stream_word
//   output    out        out_valid / out_stall      write_enable, pixel_x, pixel_y,
//                                                   color, frame_done
//   config    in         cfg_we                     cfg_index, cfg_data
//
// One word per clock while in_stall is low: a word is registered on transfer,
// parsed and clipped, and its result is pushed into the output register while
// the skid entry is empty. A skid entry behind the output register holds one
// result while out_stall is high; in_stall rises only when both output entries
// and the input register are full. rst is synchronous and returns the parser to
// the signature word and the registers to position 0,0 and a 320 by 240 screen.
`default_nettype none

module clipped_run_sprite_blitter
  import crsb_pkg::*;
#(
  parameter int MAX_SCREEN_DIM = DEFAULT_MAX_SCREEN_DIM
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] stream_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             write_enable,
  output logic [11:0]      pixel_x,
  output logic [11:0]      pixel_y,
  output logic [31:0]      color,
  output logic             frame_done
);

  logic [15:0] pos_x;
  logic [15:0] pos_y;
  logic [12:0] screen_width;
  logic [12:0] screen_height;

  logic        s1_valid;
  logic [31:0] s1_word;
  logic        accept;
  logic        advance;

  pix_req_t    req;
  result_t     res;
  result_t     dout;
  buf_stat_t   stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POS_X:         pos_x         <= cfg_data;
        REG_POS_Y:         pos_y         <= cfg_data;
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[12:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign in_stall = s1_valid && stat.skid_valid;
  assign accept   = in_valid && !in_stall;
  assign advance  = s1_valid && !stat.skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= stream_word;
    end
  end

  crsb_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .word (s1_word),
    .req  (req)
  );

  crsb_clip #(
    .MAX_SCREEN_DIM (MAX_SCREEN_DIM)
  ) u_clip (
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .req           (req),
    .res           (res)
  );

  crsb_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (advance),
    .din        (res),
    .dout       (dout),
    .dout_valid (out_valid),
    .dout_stall (out_stall),
    .stat       (stat)
  );

  assign write_enable = dout.write_enable;
  assign pixel_x      = dout.pixel_x;
  assign pixel_y      = dout.pixel_y;
  assign color        = dout.color;
  assign frame_done   = dout.frame_done;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    stat.skid_valid |-> stat.main_valid)
    else $error("skid entry holds a result while output register is empty");

  a_dropped_pixel_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (pixel_x == 12'd0 && pixel_y == 12'd0 &&
                                      color == 32'd0))
    else $error("result without write carries nonzero pixel fields");

  a_transfer_lands: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("input transfer not held in input register");

endmodule

`default_nettype wire
